### design/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants of the distance-vector route update block.
// ----------------------------------------------------------------------------
package dvru_pkg;

  // fixed field widths
  localparam int unsigned COST_W   = 16;
  localparam int unsigned NODE_W   = 4;
  // node index width that covers the largest supported node count
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_SELF_NODE = 1'b0;

  // input actions
  localparam logic ACT_LINK   = 1'b0;
  localparam logic ACT_VECTOR = 1'b1;

  // one destination travelling down the row of neighbor cells
  typedef struct packed {
    logic              valid;     // slot holds a destination
    logic              emit;      // destination is not this node
    logic              last_res;  // final emitted destination of the run
    logic              fin;       // final destination of the run
    logic [IDX_W-1:0]  d;         // destination index
    logic [COST_W-1:0] best;      // best cost so far
    logic [IDX_W-1:0]  hop;       // neighbor giving best cost
    logic              rvalid;    // some neighbor gave a route
    logic [COST_W-1:0] old;       // previous own distance to d
  } tok_t;

  // write request broadcast to all cells
  typedef struct packed {
    logic              mem_en;    // write distance entry
    logic              link_en;   // write link cost
    logic              clr;       // clearing sweep, every row at once
    logic [IDX_W-1:0]  row;       // neighbor row
    logic [IDX_W-1:0]  addr;      // destination column
    logic [COST_W-1:0] data;
  } wr_t;

endpackage

### design/dvru_cell.sv
// ----------------------------------------------------------------------------
// dvru_cell
// One neighbor of the node: holds its link cost and its distance vector,
// and folds its path cost into the running minimum of a passing item.
// ----------------------------------------------------------------------------
module dvru_cell
  import dvru_pkg::*;
#(
  parameter int J        = 0,
  parameter int NODES    = 16,
  parameter int COST_INF = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [NODE_W-1:0] self_i,
  input  wr_t               wr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam logic [COST_W-1:0] INF = COST_W'(COST_INF);

  logic [COST_W-1:0] mem_q [NODES];
  logic [COST_W-1:0] rd_q;
  logic [COST_W-1:0] link_q;
  tok_t              tok_a_q;
  tok_t              tok_b_q;
  tok_t              tok_b_d;
  logic [COST_W-1:0] wr_data;
  logic              is_self;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand;
  logic              take;

  // write data, diagonal is zero during the clearing sweep
  always_comb begin
    if (wr_i.clr) begin
      wr_data = (32'(wr_i.addr) == J) ? '0 : INF;
    end else begin
      wr_data = wr_i.data;
    end
  end

  // distance vector of this neighbor
  always_ff @(posedge clk_i) begin
    if (wr_i.mem_en && (wr_i.clr || (wr_i.row == IDX_W'(J)))) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mem_q[tok_i.d[AW-1:0]];
    end
  end

  // link cost
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= INF;
    end else if (wr_i.link_en && (wr_i.row == IDX_W'(J))) begin
      link_q <= wr_i.data;
    end
  end

  // saturating path cost and compare
  always_comb begin
    is_self = (32'(self_i) == J);
    sum     = {1'b0, rd_q} + {1'b0, link_q};
    cand    = (sum >= {1'b0, INF}) ? INF : sum[COST_W-1:0];
    take    = !is_self && (link_q != INF) && (cand < tok_a_q.best);
    tok_b_d = tok_a_q;
    if (take) begin
      tok_b_d.best   = cand;
      tok_b_d.hop    = IDX_W'(J);
      tok_b_d.rvalid = 1'b1;
    end
    if (is_self) begin
      tok_b_d.old = rd_q;
    end
  end

  // two stages: memory read, then compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
    end else if (en_i) begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
    end
  end

  assign tok_o = tok_b_q;

endmodule

### design/dvru_chain.sv
// ----------------------------------------------------------------------------
// dvru_chain
// Feeds the destinations of one recomputation run, one per cycle while enabled,
// into a row of neighbor cells and hands the finished routes out at the far end.
// ----------------------------------------------------------------------------
module dvru_chain
  import dvru_pkg::*;
#(
  parameter int NODES    = 16,
  parameter int COST_INF = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              start_i,
  input  logic [NODE_W-1:0] self_i,
  input  wr_t               wr_i,
  output tok_t              tail_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam logic [COST_W-1:0] INF = COST_W'(COST_INF);

  logic          inj_active_q;
  logic [AW-1:0] inj_d_q;
  logic [AW-1:0] last_d;
  tok_t          tok_w [NODES+1];

  // destination counter of the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_active_q <= 1'b0;
      inj_d_q      <= '0;
    end else if (start_i) begin
      inj_active_q <= 1'b1;
      inj_d_q      <= '0;
    end else if (en_i && inj_active_q) begin
      if (32'(inj_d_q) == NODES - 1) begin
        inj_active_q <= 1'b0;
      end else begin
        inj_d_q <= inj_d_q + 1'b1;
      end
    end
  end

  // final emitted destination skips this node
  assign last_d = (32'(self_i) == NODES - 1) ? AW'(NODES - 2) : AW'(NODES - 1);

  // fresh item entering the first cell
  always_comb begin
    tok_w[0]          = '0;
    tok_w[0].valid    = inj_active_q;
    tok_w[0].emit     = (32'(inj_d_q) != 32'(self_i));
    tok_w[0].last_res = (inj_d_q == last_d);
    tok_w[0].fin      = (32'(inj_d_q) == NODES - 1);
    tok_w[0].d        = IDX_W'(inj_d_q);
    tok_w[0].best     = INF;
    tok_w[0].old      = INF;
  end

  // row of neighbor cells
  for (genvar k = 0; k < NODES; k++) begin : g_cell
    dvru_cell #(
      .J        (k),
      .NODES    (NODES),
      .COST_INF (COST_INF)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .self_i (self_i),
      .wr_i   (wr_i),
      .tok_i  (tok_w[k]),
      .tok_o  (tok_w[k+1])
    );
  end

  assign tail_o = tok_w[NODES];

endmodule

### design/distance_vector_route_update_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_top
// Distance-vector routing node: link costs, neighbor vectors and route
// recomputation over a row of neighbor cells.
// ----------------------------------------------------------------------------
// A link change, or the last element of a neighbor vector, starts a run that
// reports one route per destination other than this node, in ascending order,
// with the advertise flag on the final route. Vector elements that are not
// last only write the neighbor vector. A run sends the NODES destinations
// one per cycle, while the output does not stall, through NODES neighbor
// cells of two stages each (memory read, then compare); the next item is
// taken only after the final destination of the run has left the chain.
// After reset the distance memories are cleared, all cells in parallel,
// during which no item is taken.
// ----------------------------------------------------------------------------
module distance_vector_route_update_top
  import dvru_pkg::*;
#(
  parameter int NODES    = 16,
  parameter int COST_INF = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [NODE_W-1:0]  node_i,
  input  logic [NODE_W-1:0]  dest_i,
  input  logic [COST_W-1:0]  cost_i,
  input  logic               last_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NODE_W-1:0]  route_dest_o,
  output logic [NODE_W-1:0]  next_hop_o,
  output logic               route_valid_o,
  output logic [COST_W-1:0]  route_cost_o,
  output logic               vector_changed_o,
  output logic               last_result_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam logic [COST_W-1:0] INF = COST_W'(COST_INF);

  logic [NODE_W-1:0] self_q;
  logic              clr_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              busy_q;
  logic              changed_q;
  logic              out_valid_q;
  logic              accept;
  logic              start;
  logic              node_ok;
  logic              dest_ok;
  logic              self_ok;
  logic              chain_en;
  logic              tail_emit;
  logic              diff;
  logic [COST_W-1:0] cost_clamped;
  wr_t               wr;
  tok_t              tail;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SELF_NODE) ? PDATA_W'(self_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SELF_NODE)) begin
      self_q <= pwdata[NODE_W-1:0];
    end
  end

  // input handshake and decode
  assign in_stall_o   = clr_q || busy_q;
  assign accept       = in_valid_i && !in_stall_o;
  assign node_ok      = (32'(node_i) < NODES);
  assign dest_ok      = (32'(dest_i) < NODES);
  assign self_ok      = (32'(self_q) < NODES);
  assign cost_clamped = (cost_i > INF) ? INF : cost_i;
  assign start        = accept && ((action_i == ACT_LINK) || last_i);

  // chain advances whenever the output register can take a route
  assign chain_en  = !out_valid_q || !out_stall_i;
  assign tail_emit = tail.valid && tail.emit;
  assign diff      = self_ok && (tail.old != tail.best);

  // write request: clearing sweep, own row update, or input item
  always_comb begin
    wr = '0;
    if (clr_q) begin
      wr.mem_en = 1'b1;
      wr.clr    = 1'b1;
      wr.addr   = IDX_W'(clr_cnt_q);
    end else if (busy_q) begin
      wr.mem_en = chain_en && tail_emit && self_ok;
      wr.row    = IDX_W'(self_q);
      wr.addr   = tail.d;
      wr.data   = tail.best;
    end else begin
      wr.mem_en  = accept && (action_i == ACT_VECTOR) && node_ok && dest_ok;
      wr.link_en = accept && (action_i == ACT_LINK) && node_ok;
      wr.row     = IDX_W'(node_i);
      wr.addr    = IDX_W'(dest_i);
      wr.data    = cost_clamped;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (32'(clr_cnt_q) == NODES - 1) begin
        clr_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // run tracking and change flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      changed_q <= 1'b0;
    end else if (start) begin
      busy_q    <= 1'b1;
      changed_q <= 1'b0;
    end else if (chain_en && tail.valid) begin
      if (tail.fin) begin
        busy_q <= 1'b0;
      end
      if (tail.emit) begin
        changed_q <= changed_q || diff;
      end
    end
  end

  dvru_chain #(
    .NODES    (NODES),
    .COST_INF (COST_INF)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (chain_en),
    .start_i (start),
    .self_i  (self_q),
    .wr_i    (wr),
    .tail_o  (tail)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_en) begin
      out_valid_q <= tail_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_en && tail_emit) begin
      route_dest_o     <= NODE_W'(tail.d);
      next_hop_o       <= NODE_W'(tail.hop);
      route_valid_o    <= tail.rvalid;
      route_cost_o     <= tail.best;
      vector_changed_o <= tail.last_res && (changed_q || diff);
      last_result_o    <= tail.last_res;
    end
  end

  assign out_valid_o = out_valid_q;

  // routes only leave the chain during a run
  a_tail_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("route left the chain outside a run");

  // advertise flag only on the final route
  a_changed_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vector_changed_o) |-> last_result_o)
    else $error("vector_changed without last_result");

  // a valid route never has infinite cost
  a_route_finite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && route_valid_o) |-> (route_cost_o != INF))
    else $error("valid route with infinite cost");

  // no item taken during the clearing sweep or a run
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_q || busy_q) |-> !accept)
    else $error("item accepted while busy");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the distance-vector route update block. Link
// changes and neighbor vector elements are driven through the input channel.
// A local route predictor keeps its own distance and link tables and queues
// the routes expected from each recomputation. Every result item is checked
// field by field. Both channels idle at random, and one phase holds the
// result channel off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import dvru_pkg::*;

  localparam int NODE_CNT = 16;
  localparam logic [COST_W-1:0] COST_INF = 16'hFFFF;
  // time for a run to drain through the neighbor cells, with margin
  localparam int RUN_LATENCY = 3 * NODE_CNT + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [NODE_W-1:0] route_dest;
    logic [NODE_W-1:0] next_hop;
    logic              route_valid;
    logic [COST_W-1:0] route_cost;
    logic              vector_changed;
    logic              last_result;
  } route_t;

  // block ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = ACT_LINK;
  logic [NODE_W-1:0]  node_i = '0;
  logic [NODE_W-1:0]  dest_i = '0;
  logic [COST_W-1:0]  cost_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [NODE_W-1:0]  route_dest_o;
  logic [NODE_W-1:0]  next_hop_o;
  logic               route_valid_o;
  logic [COST_W-1:0]  route_cost_o;
  logic               vector_changed_o;
  logic               last_result_o;

  // predictor state
  logic [COST_W-1:0]  dist_mem [NODE_CNT][NODE_CNT];
  logic [COST_W-1:0]  link_mem [NODE_CNT];
  logic [NODE_W-1:0]  self_id;
  route_t             route_q[$];
  route_t             want_route;

  // run control
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_off_req = 1'b0;

  distance_vector_route_update_top #(
    .NODES    (NODE_CNT),
    .COST_INF (COST_INF)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .node_i           (node_i),
    .dest_i           (dest_i),
    .cost_i           (cost_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .route_dest_o     (route_dest_o),
    .next_hop_o       (next_hop_o),
    .route_valid_o    (route_valid_o),
    .route_cost_o     (route_cost_o),
    .vector_changed_o (vector_changed_o),
    .last_result_o    (last_result_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // route predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_routing_state();
    for (int i = 0; i < NODE_CNT; i++) begin
      for (int j = 0; j < NODE_CNT; j++) begin
        dist_mem[i][j] = (i == j) ? '0 : COST_INF;
      end
      link_mem[i] = COST_INF;
    end
    self_id = '0;
  endfunction

  // bellman-ford pass over all destinations but this node
  function automatic void recompute_routes();
    logic [COST_W-1:0] best;
    logic [NODE_W-1:0] hop;
    logic              found;
    logic              changed;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] path;
    route_t            r;
    int                last_d;
    changed = 1'b0;
    last_d = (self_id == NODE_CNT - 1) ? NODE_CNT - 2 : NODE_CNT - 1;
    for (int d = 0; d < NODE_CNT; d++) begin
      if (d != self_id) begin
        best = COST_INF;
        hop = '0;
        found = 1'b0;
        for (int j = 0; j < NODE_CNT; j++) begin
          if (j != self_id && link_mem[j] != COST_INF) begin
            // saturating sum, infinity never gives a route
            sum = {1'b0, dist_mem[j][d]} + {1'b0, link_mem[j]};
            path = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
            // strict compare keeps the lowest index on a tie
            if (path < best) begin
              best = path;
              hop = j[NODE_W-1:0];
              found = 1'b1;
            end
          end
        end
        if (dist_mem[self_id][d] != best) changed = 1'b1;
        dist_mem[self_id][d] = best;
        r.route_dest = d[NODE_W-1:0];
        r.next_hop = found ? hop : '0;
        r.route_valid = found;
        r.route_cost = best;
        r.vector_changed = (d == last_d) ? changed : 1'b0;
        r.last_result = (d == last_d);
        route_q.push_back(r);
      end
    end
  endfunction

  function automatic void predict_item(logic act, logic [NODE_W-1:0] nd,
                                       logic [NODE_W-1:0] ds, logic [COST_W-1:0] c,
                                       logic lst);
    if (act == ACT_LINK) begin
      link_mem[nd] = c;
      recompute_routes();
    end else begin
      dist_mem[nd][ds] = c;
      if (lst) recompute_routes();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [COST_W-1:0] got,
                             logic [COST_W-1:0] want, logic [NODE_W-1:0] d);
    if (got !== want) begin
      report_mismatch($sformatf("dest %0d %s got %0h want %0h", d, name, got, want));
    end
  endtask

  // compare each result item with the oldest pending route
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (route_q.size() == 0) begin
        report_mismatch($sformatf("route to %0d with nothing pending", route_dest_o));
      end else begin
        want_route = route_q.pop_front();
        check_field("route_dest", COST_W'(route_dest_o), COST_W'(want_route.route_dest),
                    want_route.route_dest);
        check_field("next_hop", COST_W'(next_hop_o), COST_W'(want_route.next_hop),
                    want_route.route_dest);
        check_field("route_valid", COST_W'(route_valid_o),
                    COST_W'(want_route.route_valid), want_route.route_dest);
        check_field("route_cost", route_cost_o, want_route.route_cost,
                    want_route.route_dest);
        check_field("vector_changed", COST_W'(vector_changed_o),
                    COST_W'(want_route.vector_changed), want_route.route_dest);
        check_field("last_result", COST_W'(last_result_o),
                    COST_W'(want_route.last_result), want_route.route_dest);
      end
    end
  end

  // result side stalls, plus the long hold-off on request
  initial begin : out_stall_gen
    int unsigned burst;
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk_i);
          held++;
        end
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        burst = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic act, logic [NODE_W-1:0] nd, logic [NODE_W-1:0] ds,
                           logic [COST_W-1:0] c, logic lst);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    node_i <= nd;
    dest_i <= ds;
    cost_i <= c;
    last_i <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_item(act, nd, ds, c, lst);
  endtask

  // wait for every pending route, then let trailing items settle
  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (RUN_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_self_node(logic [NODE_W-1:0] id);
    logic [PDATA_W-1:0] rd;
    drain_and_idle();
    // write: setup then access
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SELF_NODE, 2'b00};
    pwdata <= {{(PDATA_W - NODE_W){1'b0}}, id};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    self_id = id;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (rd !== {{(PDATA_W - NODE_W){1'b0}}, id}) begin
      report_mismatch($sformatf("self_node read %0h want %0h", rd, id));
    end
  endtask

  function automatic logic [COST_W-1:0] pick_link_cost();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return COST_INF;
    if (r < 22) return COST_W'($urandom_range(0, 65535));
    return COST_W'($urandom_range(1, 40));
  endfunction

  function automatic logic [COST_W-1:0] pick_vector_cost();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return COST_INF;
    if (r < 20) return COST_INF - 16'd1;
    if (r < 27) return COST_W'($urandom_range(0, 65535));
    if (r < 32) return '0;
    return COST_W'($urandom_range(0, 60));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // link changes at the cost extremes, own link excluded, link removal
  task automatic test_link_changes();
    send_item(ACT_LINK, 4'd1, 4'd0, 16'd5, 1'b0);
    send_item(ACT_LINK, 4'd15, 4'd15, 16'd0, 1'b1);
    send_item(ACT_LINK, 4'd2, 4'd9, COST_INF - 16'd1, 1'b0);
    send_item(ACT_LINK, 4'd0, 4'd3, 16'd3, 1'b0);
    send_item(ACT_LINK, 4'd1, 4'd0, COST_INF, 1'b0);
  endtask

  // elements without last, infinite elements, own row written by a vector
  task automatic test_vector_cases();
    send_item(ACT_VECTOR, 4'd2, 4'd5, 16'd1, 1'b0);
    send_item(ACT_VECTOR, 4'd2, 4'd0, 16'd0, 1'b0);
    send_item(ACT_VECTOR, 4'd15, 4'd5, COST_INF, 1'b0);
    send_item(ACT_VECTOR, 4'd15, 4'd7, COST_INF - 16'd1, 1'b1);
    send_item(ACT_VECTOR, 4'd0, 4'd9, 16'd7, 1'b1);
  endtask

  // equal sums from three neighbors, sums just below and at infinity
  task automatic test_tie_and_saturation();
    send_item(ACT_LINK, 4'd3, 4'd0, 16'd10, 1'b0);
    send_item(ACT_LINK, 4'd4, 4'd0, 16'd4, 1'b0);
    send_item(ACT_VECTOR, 4'd3, 4'd6, 16'd2, 1'b0);
    send_item(ACT_VECTOR, 4'd4, 4'd6, 16'd8, 1'b0);
    send_item(ACT_VECTOR, 4'd15, 4'd6, 16'd12, 1'b1);
    send_item(ACT_VECTOR, 4'd3, 4'd11, 16'd65525, 1'b0);
    send_item(ACT_VECTOR, 4'd4, 4'd11, 16'd65530, 1'b1);
  endtask

  // highest node id, then a middle one with a link to itself
  task automatic test_self_node_extremes();
    set_self_node(4'd15);
    send_item(ACT_LINK, 4'd0, 4'd0, 16'd1, 1'b0);
    send_item(ACT_VECTOR, 4'd15, 4'd3, 16'd2, 1'b1);
    set_self_node(4'd7);
    send_item(ACT_LINK, 4'd7, 4'd2, 16'd9, 1'b1);
  endtask

  // mostly well-formed vectors and link changes, some stray elements
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] ds;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_item(ACT_LINK, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom_range(0, 15)),
                  pick_link_cost(), 1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 85) begin
        src = NODE_W'($urandom_range(0, 15));
        ds = NODE_W'($urandom_range(0, 15));
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_item(ACT_VECTOR, src, ds, pick_vector_cost(), k == len - 1);
          ds = ds + NODE_W'($urandom_range(1, 3));
          sent++;
        end
      end else begin
        send_item(ACT_VECTOR, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom_range(0, 15)),
                  COST_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // results held off while every item starts a run, so the input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      if (i % 2 == 0) begin
        send_item(ACT_LINK, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom_range(0, 15)),
                  pick_link_cost(), 1'b0);
      end else begin
        send_item(ACT_VECTOR, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom_range(0, 15)),
                  pick_vector_cost(), 1'b1);
      end
    end
  endtask

  // main sequence
  initial begin
    reset_routing_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_self_node(4'd0);
    test_link_changes();
    test_vector_cases();
    test_tie_and_saturation();
    test_self_node_extremes();
    test_random_traffic(110);
    set_self_node(4'd15);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(70);
    set_self_node(NODE_W'($urandom_range(1, 14)));
    gaps_on = 1'b1;
    stall_on = 1'b1;
    test_random_traffic(110);
    test_backpressure();
    drain_and_idle();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/dvru_pkg.sv
design/dvru_cell.sv
design/dvru_chain.sv
design/distance_vector_route_update_top.sv
verif/testbench.sv
